### rtl/best_fit_block_allocator_defines.svh
// Assertion helpers for the best-fit allocator
`ifndef BEST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication
`define BFBA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BFBA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bfba_pkg.sv
package bfba_pkg;

  localparam int unsigned WasteW = 20;
  localparam int unsigned IndexW = 4;
  localparam int unsigned InSizeW = 16;
  localparam logic [WasteW-1:0] WasteMax = '1;

  typedef enum logic [1:0] {
    ST_LOADED  = 2'd0,
    ST_PLACED  = 2'd1,
    ST_WAITING = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_REQ  = 1'b1;

endpackage

### rtl/best_fit_block_allocator.sv
// Best-fit allocator over a table of MAX_BLOCKS fixed partitions. A load item
// (mode 0) appends a block size; a full table answers status full. A request
// item (mode 1) walks the loaded slots through the size memory's single read
// port, one slot per cycle, with one compare stage choosing the smallest free
// block that fits (lowest index on ties). The block takes no new item while
// one is in work; a finished result waits in the output register until taken.
// Sizes are taken modulo 2^SIZE_BITS and both waste totals saturate at
// 2^20 - 1. block_index carries the low four bits of the slot number.
`include "best_fit_block_allocator_defines.svh"

module best_fit_block_allocator
  import bfba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 16,
  parameter int unsigned SIZE_BITS  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               in_mode_i,
  input  logic [InSizeW-1:0] in_size_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         out_status_o,
  output logic [IndexW-1:0]  out_block_index_o,
  output logic [WasteW-1:0]  out_internal_waste_o,
  output logic [WasteW-1:0]  out_external_waste_o
);

  localparam int unsigned IdxW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned FreeW = SIZE_BITS + IdxW + 1;
  localparam int unsigned SumW  = SIZE_BITS + WasteW + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [SIZE_BITS-1:0] mem_q [MAX_BLOCKS];
  logic [SIZE_BITS-1:0] rdata_q;

  logic [2:0]            state_q, state_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [MAX_BLOCKS-1:0] used_q, used_d;
  logic [IdxW-1:0]       ptr_q, ptr_d;
  logic                  pipe_v_q, pipe_v_d;
  logic [IdxW-1:0]       pipe_idx_q, pipe_idx_d;
  logic [SIZE_BITS-1:0]  req_q, req_d;
  logic                  found_q, found_d;
  logic [IdxW-1:0]       best_idx_q, best_idx_d;
  logic [SIZE_BITS-1:0]  best_size_q, best_size_d;
  logic [WasteW-1:0]     internal_q, internal_d;
  logic [FreeW-1:0]      free_q, free_d;
  status_e               res_status_q, res_status_d;
  logic [IdxW-1:0]       res_idx_q, res_idx_d;

  logic                  out_valid_q, out_valid_d;
  logic [1:0]            out_status_q, out_status_d;
  logic [IndexW-1:0]     out_idx_q, out_idx_d;
  logic [WasteW-1:0]     out_int_q, out_int_d;
  logic [WasteW-1:0]     out_ext_q, out_ext_d;

  logic                  mem_we;
  logic [IdxW-1:0]       mem_waddr;
  logic [SIZE_BITS+InSizeW-1:0] size_ext;
  logic [SIZE_BITS-1:0]  in_size;
  logic                  in_acc;
  logic                  fit;
  logic                  last_slot;
  logic [SIZE_BITS-1:0]  excess;
  logic [SumW-1:0]       waste_sum;
  logic [FreeW+WasteW-1:0] free_ext;
  logic [WasteW-1:0]     free_sat;
  logic [IdxW+IndexW-1:0] idx_ext;

  assign size_ext  = {{SIZE_BITS{1'b0}}, in_size_i};
  assign in_size   = size_ext[SIZE_BITS-1:0];
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc    = in_valid_i && !in_stall_o;
  assign fit       = pipe_v_q && (rdata_q >= req_q) && (!found_q || rdata_q < best_size_q);
  assign last_slot = (CntW'(ptr_q) + CntW'(1)) == cnt_q;
  assign excess    = best_size_q - req_q;
  assign waste_sum = SumW'(internal_q) + SumW'(excess);
  assign free_ext  = {{WasteW{1'b0}}, free_q};
  assign free_sat  = (free_ext > (FreeW+WasteW)'(WasteMax)) ? WasteMax : free_ext[WasteW-1:0];
  assign idx_ext   = {{IndexW{1'b0}}, res_idx_q};

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    used_d       = used_q;
    ptr_d        = ptr_q;
    pipe_v_d     = 1'b0;
    pipe_idx_d   = ptr_q;
    req_d        = req_q;
    found_d      = found_q;
    best_idx_d   = best_idx_q;
    best_size_d  = best_size_q;
    internal_d   = internal_q;
    free_d       = free_q;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    mem_we       = 1'b0;
    mem_waddr    = cnt_q[IdxW-1:0];
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_idx_d    = out_idx_q;
    out_int_d    = out_int_q;
    out_ext_d    = out_ext_q;

    if (fit) begin
      found_d     = 1'b1;
      best_idx_d  = pipe_idx_q;
      best_size_d = rdata_q;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_idx_d = '0;
          state_d   = S_DONE;
          if (in_mode_i == MODE_LOAD) begin
            if (cnt_q == CntW'(MAX_BLOCKS)) begin
              res_status_d = ST_FULL;
            end else begin
              mem_we                    = 1'b1;
              used_d[cnt_q[IdxW-1:0]]   = 1'b0;
              cnt_d                     = cnt_q + CntW'(1);
              free_d                    = free_q + FreeW'(in_size);
              res_status_d              = ST_LOADED;
              res_idx_d                 = cnt_q[IdxW-1:0];
            end
          end else begin
            req_d        = in_size;
            found_d      = 1'b0;
            ptr_d        = '0;
            res_status_d = ST_WAITING;
            if (cnt_q != '0) begin
              state_d = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        pipe_v_d = !used_q[ptr_q];
        ptr_d    = ptr_q + IdxW'(1);
        if (last_slot) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        if (found_q) begin
          used_d[best_idx_q] = 1'b1;
          internal_d   = (waste_sum > SumW'(WasteMax)) ? WasteMax : waste_sum[WasteW-1:0];
          free_d       = free_q - FreeW'(best_size_q);
          res_status_d = ST_PLACED;
          res_idx_d    = best_idx_q;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_idx_d    = idx_ext[IndexW-1:0];
          out_int_d    = internal_q;
          out_ext_d    = free_sat;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      used_q      <= '0;
      ptr_q       <= '0;
      pipe_v_q    <= 1'b0;
      found_q     <= 1'b0;
      internal_q  <= '0;
      free_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      used_q      <= used_d;
      ptr_q       <= ptr_d;
      pipe_v_q    <= pipe_v_d;
      found_q     <= found_d;
      internal_q  <= internal_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_idx_q   <= pipe_idx_d;
    req_q        <= req_d;
    best_idx_q   <= best_idx_d;
    best_size_q  <= best_size_d;
    res_status_q <= res_status_d;
    res_idx_q    <= res_idx_d;
    out_status_q <= out_status_d;
    out_idx_q    <= out_idx_d;
    out_int_q    <= out_int_d;
    out_ext_q    <= out_ext_d;
  end

  // size table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= in_size;
    end
    rdata_q <= mem_q[ptr_q];
  end

  assign out_valid_o          = out_valid_q;
  assign out_status_o         = out_status_q;
  assign out_block_index_o    = out_idx_q;
  assign out_internal_waste_o = out_int_q;
  assign out_external_waste_o = out_ext_q;

  `BFBA_ASSERT_NXT(a_mark_used, (state_q == S_UPD) && found_q, used_q[$past(best_idx_q)], "chosen block not marked used")
  `BFBA_ASSERT_IMP(a_best_fits, (state_q == S_UPD) && found_q, best_size_q >= req_q, "chosen block smaller than request")
  `BFBA_ASSERT_NXT(a_load_count, in_acc && (in_mode_i == MODE_LOAD) && (cnt_q != CntW'(MAX_BLOCKS)), cnt_q == $past(cnt_q) + CntW'(1), "load did not advance count")
  `BFBA_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= CntW'(MAX_BLOCKS), "block count beyond table")

endmodule

### tb/alloc_checker.sv
`timescale 1ns / 1ps

module alloc_checker
  import bfba_pkg::*;
#(
  parameter int unsigned Slots    = 16,
  parameter int unsigned SizeBits = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               in_mode_i,
  input  logic [InSizeW-1:0] in_size_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [1:0]         out_status_i,
  input  logic [IndexW-1:0]  out_block_index_i,
  input  logic [WasteW-1:0]  out_internal_waste_i,
  input  logic [WasteW-1:0]  out_external_waste_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    status_e             status;
    logic [IndexW-1:0]   index;
    logic [WasteW-1:0]   internal_waste;
    logic [WasteW-1:0]   external_waste;
  } alloc_result_t;

  logic [InSizeW-1:0] slot_size [Slots];
  bit                 slot_used [Slots];
  int unsigned        slot_count;
  logic [WasteW-1:0]  waste_internal;
  logic [WasteW-1:0]  waste_free;
  alloc_result_t      expected_q [$];

  function automatic logic [WasteW-1:0] sat_waste(input longint unsigned v);
    return (v > WasteMax) ? WasteMax : WasteW'(v);
  endfunction

  function automatic void refresh_free();
    longint unsigned sum;
    sum = 0;
    for (int i = 0; i < slot_count; i++) begin
      if (!slot_used[i]) sum += slot_size[i];
    end
    waste_free = sat_waste(sum);
  endfunction

  function automatic alloc_result_t predict_alloc(input logic mode,
                                                  input logic [InSizeW-1:0] raw);
    alloc_result_t      r;
    logic [InSizeW-1:0] sz;
    int                 best;
    sz      = raw & InSizeW'((64'd1 << SizeBits) - 1);
    r.index = '0;
    best    = -1;
    if (mode == MODE_LOAD) begin
      if (slot_count >= Slots) begin
        r.status = ST_FULL;
      end else begin
        slot_size[slot_count] = sz;
        slot_used[slot_count] = 1'b0;
        r.index               = IndexW'(slot_count);
        slot_count++;
        refresh_free();
        r.status = ST_LOADED;
      end
    end else begin
      // smallest fitting free block, lowest index on ties
      for (int i = 0; i < slot_count; i++) begin
        if (!slot_used[i] && slot_size[i] >= sz &&
            (best < 0 || slot_size[i] < slot_size[best])) best = i;
      end
      if (best >= 0) begin
        slot_used[best] = 1'b1;
        waste_internal  = sat_waste(longint'(waste_internal) +
                                    longint'(slot_size[best] - sz));
        refresh_free();
        r.index  = IndexW'(best);
        r.status = ST_PLACED;
      end else begin
        r.status = ST_WAITING;
      end
    end
    r.internal_waste = waste_internal;
    r.external_waste = waste_free;
    return r;
  endfunction

  task automatic note_failure(input string what, input longint unsigned want,
                              input longint unsigned got);
    fail_count_o++;
    if (fail_count_o <= 10) begin
      $display("%0t checker: %s expected %0d got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t want;
    if (!rst_ni) begin
      slot_count     = 0;
      waste_internal = '0;
      waste_free     = '0;
      fail_count_o   = 0;
      for (int i = 0; i < Slots; i++) slot_used[i] = 1'b0;
      expected_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          note_failure("result with nothing pending, status", 0, out_status_i);
        end else begin
          want = expected_q.pop_front();
          if (out_status_i !== want.status)
            note_failure("status", want.status, out_status_i);
          if (out_block_index_i !== want.index)
            note_failure("block_index", want.index, out_block_index_i);
          if (out_internal_waste_i !== want.internal_waste)
            note_failure("internal_waste", want.internal_waste, out_internal_waste_i);
          if (out_external_waste_i !== want.external_waste)
            note_failure("external_waste", want.external_waste, out_external_waste_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_q.push_back(predict_alloc(in_mode_i, in_size_i));
      end
    end
    pending_o = expected_q.size();
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import bfba_pkg::*;

  localparam int unsigned Slots       = 16;
  localparam int unsigned SizeBits    = 16;
  localparam int unsigned NumRandom   = 1435;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 30;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_mode_i   = MODE_LOAD;
  logic [InSizeW-1:0] in_size_i   = '0;
  logic               out_stall_i = 1'b0;

  logic               in_stall_o;
  logic               out_valid_o;
  logic [1:0]         out_status_o;
  logic [IndexW-1:0]  out_block_index_o;
  logic [WasteW-1:0]  out_internal_waste_o;
  logic [WasteW-1:0]  out_external_waste_o;

  int                 fail_count;
  int                 pending;
  int unsigned        tx_idle_pct = 14;
  int unsigned        rx_idle_pct = 70;
  bit                 hold_go     = 1'b0;
  logic [InSizeW-1:0] loaded_sizes [$];

  always #10 clk_i = ~clk_i;

  best_fit_block_allocator #(
    .MAX_BLOCKS(Slots),
    .SIZE_BITS (SizeBits)
  ) uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .in_mode_i           (in_mode_i),
    .in_size_i           (in_size_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_status_o        (out_status_o),
    .out_block_index_o   (out_block_index_o),
    .out_internal_waste_o(out_internal_waste_o),
    .out_external_waste_o(out_external_waste_o)
  );

  alloc_checker #(
    .Slots   (Slots),
    .SizeBits(SizeBits)
  ) u_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_i          (in_stall_o),
    .in_mode_i           (in_mode_i),
    .in_size_i           (in_size_i),
    .out_valid_i         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_status_i        (out_status_o),
    .out_block_index_i   (out_block_index_o),
    .out_internal_waste_i(out_internal_waste_o),
    .out_external_waste_i(out_external_waste_o),
    .fail_count_o        (fail_count),
    .pending_o           (pending)
  );

  task automatic send_item(input logic mode, input logic [InSizeW-1:0] sz);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_mode_i  <= mode;
    in_size_i  <= sz;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (mode == MODE_LOAD) loaded_sizes.push_back(sz);
  endtask

  function automatic logic [InSizeW-1:0] pick_load();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 3) return InSizeW'($urandom_range(15));
    if (sel < 5 && loaded_sizes.size() != 0) return loaded_sizes[$];
    return InSizeW'($urandom);
  endfunction

  // half the time a size close to a loaded block, so fits, ties and misses all occur
  function automatic logic [InSizeW-1:0] pick_request();
    int unsigned        sel;
    int unsigned        d;
    logic [InSizeW-1:0] base;
    sel = $urandom_range(9);
    if (sel < 3 || loaded_sizes.size() == 0) return InSizeW'($urandom);
    if (sel < 5) return InSizeW'($urandom_range(7));
    base = loaded_sizes[$urandom_range(loaded_sizes.size() - 1)];
    d    = $urandom_range(4);
    if (d == 4) return (base == '1) ? base : base + 1'b1;
    return (base > d) ? base - InSizeW'(d) : '0;
  endfunction

  initial begin : receiver
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_go && !held) begin
        held      = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= (rx_idle_pct != 0) && ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle = 0;
      else idle++;
    end
    $display("tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, then ties, exact fits and best fit over first fit
    send_item(MODE_REQ, '0);
    send_item(MODE_REQ, '1);
    send_item(MODE_LOAD, '0);
    send_item(MODE_LOAD, 16'd100);
    send_item(MODE_LOAD, 16'd100);
    send_item(MODE_LOAD, '1);
    send_item(MODE_REQ, '0);
    send_item(MODE_REQ, '0);
    send_item(MODE_REQ, 16'd101);
    send_item(MODE_REQ, 16'd1);
    send_item(MODE_REQ, 16'd1);
    send_item(MODE_LOAD, 16'h8000);
    send_item(MODE_LOAD, 16'h7fff);
    send_item(MODE_REQ, 16'h7fff);
    send_item(MODE_REQ, 16'h7fff);

    for (int k = 0; k < NumRandom; k++) begin
      if (k == NumRandom / 3) begin
        tx_idle_pct = 70;
        rx_idle_pct = 14;
      end
      if (k == 2 * NumRandom / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_go     = 1'b1;
      end
      if ($urandom_range(39) == 0 ||
          (loaded_sizes.size() >= Slots && $urandom_range(9) == 0))
        send_item(MODE_LOAD, pick_load());
      else
        send_item(MODE_REQ, pick_request());
    end
    in_valid_i <= 1'b0;

    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/bfba_pkg.sv
rtl/best_fit_block_allocator.sv
tb/alloc_checker.sv
tb/tb.sv
